// ===== rtl/ibd_pkg.sv =====
package ibd_pkg;

    localparam int IMAGE_SIDE_DEF = 256;
    localparam int SUM_DEPTH_DEF  = 128;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CHAN_W         = 8;
    localparam int SUM_W          = 12;
    localparam int NUM_CHAN       = 3;
    localparam int CFG_W          = 3;
    localparam int OUT_POS_W      = 7;

    // floor(x/9) == (x*3641) >> 15 for every x below 4096
    localparam int RECIP9       = 3641;
    localparam int RECIP9_SHIFT = 15;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    red_avg;
        logic [CHAN_W-1:0]    green_avg;
        logic [CHAN_W-1:0]    blue_avg;
        logic [OUT_POS_W-1:0] out_col;
        logic [OUT_POS_W-1:0] out_row;
        logic                 frame_last;
    } result_t;

    typedef enum logic [1:0] {
        FAC_2,
        FAC_3,
        FAC_4
    } fac_t;

    typedef struct packed {
        pixel_t               pix;
        fac_t                 fac;
        logic                 first;
        logic                 last;
        logic                 frame_last;
        logic [OUT_POS_W-1:0] out_col;
        logic [OUT_POS_W-1:0] out_row;
    } blk_ctl_t;

    function automatic logic [CHAN_W-1:0] box_mean(logic [SUM_W-1:0] sum, fac_t fac);
        logic [2*SUM_W-1:0] prod;
        logic [CHAN_W-1:0]  q;
        prod = {{SUM_W{1'b0}}, sum} * (2*SUM_W)'(RECIP9);
        unique case (fac)
            FAC_2:   q = sum[2 +: CHAN_W];
            FAC_3:   q = prod[RECIP9_SHIFT +: CHAN_W];
            FAC_4:   q = sum[4 +: CHAN_W];
            default: q = sum[4 +: CHAN_W];
        endcase
        return q;
    endfunction

endpackage

// ===== rtl/ibd_front.sv =====
module ibd_front #(
    parameter int IMAGE_SIDE = ibd_pkg::IMAGE_SIDE_DEF,
    parameter int SUM_DEPTH  = ibd_pkg::SUM_DEPTH_DEF,
    parameter int COL_W      = $clog2(SUM_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [ibd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       pixel_valid,
    input  ibd_pkg::pixel_t            pixel,
    input  logic                       q_full,
    output logic                       q_push,
    output logic [COL_W-1:0]           q_col,
    output ibd_pkg::blk_ctl_t          q_ctl
);

    localparam int POS_W = $clog2(IMAGE_SIDE);
    localparam int BLK2  = IMAGE_SIDE / 2;
    localparam int BLK3  = IMAGE_SIDE / 3;
    localparam int BLK4  = IMAGE_SIDE / 4;
    localparam int LAST2 = ((BLK2 < SUM_DEPTH) ? BLK2 : SUM_DEPTH) - 1;
    localparam int LAST3 = ((BLK3 < SUM_DEPTH) ? BLK3 : SUM_DEPTH) - 1;
    localparam int LAST4 = ((BLK4 < SUM_DEPTH) ? BLK4 : SUM_DEPTH) - 1;

    ibd_pkg::fac_t    fac_reg, fac_next;
    logic [POS_W-1:0] in_col_reg, in_col_next;
    logic [POS_W-1:0] in_row_reg, in_row_next;
    logic [1:0]       col_phase_reg, col_phase_next;
    logic [1:0]       row_phase_reg, row_phase_next;
    logic [POS_W-1:0] block_col_reg, block_col_next;
    logic [POS_W-1:0] block_row_reg, block_row_next;

    logic [POS_W:0]   span;
    logic [POS_W-1:0] last_blk;
    logic [POS_W-1:0] last_col;
    logic [1:0]       fm1;
    logic             keep;
    logic             take;

    always_comb
    begin
        unique case (fac_reg)
            ibd_pkg::FAC_2:
            begin
                span     = (POS_W+1)'(BLK2 * 2);
                last_blk = POS_W'(BLK2 - 1);
                last_col = POS_W'(LAST2);
                fm1      = 2'd1;
            end
            ibd_pkg::FAC_3:
            begin
                span     = (POS_W+1)'(BLK3 * 3);
                last_blk = POS_W'(BLK3 - 1);
                last_col = POS_W'(LAST3);
                fm1      = 2'd2;
            end
            default:
            begin
                span     = (POS_W+1)'(BLK4 * 4);
                last_blk = POS_W'(BLK4 - 1);
                last_col = POS_W'(LAST4);
                fm1      = 2'd3;
            end
        endcase
    end

    assign take = pixel_valid && !q_full;
    assign keep = ({1'b0, in_col_reg} < span) && ({1'b0, in_row_reg} < span)
                  && (32'(block_col_reg) < SUM_DEPTH);
    assign q_push = take && keep;
    assign q_col  = COL_W'(block_col_reg);

    always_comb
    begin
        q_ctl.pix        = pixel;
        q_ctl.fac        = fac_reg;
        q_ctl.first      = (col_phase_reg == 2'd0) && (row_phase_reg == 2'd0);
        q_ctl.last       = (col_phase_reg == fm1) && (row_phase_reg == fm1);
        q_ctl.frame_last = (block_col_reg == last_col) && (block_row_reg == last_blk);
        q_ctl.out_col    = ibd_pkg::OUT_POS_W'(block_col_reg);
        q_ctl.out_row    = ibd_pkg::OUT_POS_W'(block_row_reg);
    end

    always_comb
    begin
        fac_next       = fac_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        block_col_next = block_col_reg;
        block_row_next = block_row_reg;
        if (cfg_valid)
        begin
            priority if (cfg_data == 3'd3)
                fac_next = ibd_pkg::FAC_3;
            else if (cfg_data >= 3'd4)
                fac_next = ibd_pkg::FAC_4;
            else
                fac_next = ibd_pkg::FAC_2;
            in_col_next    = '0;
            in_row_next    = '0;
            col_phase_next = '0;
            row_phase_next = '0;
            block_col_next = '0;
            block_row_next = '0;
        end
        else if (take)
        begin
            if (in_col_reg == POS_W'(IMAGE_SIDE - 1))
            begin
                in_col_next    = '0;
                col_phase_next = '0;
                block_col_next = '0;
                if (in_row_reg == POS_W'(IMAGE_SIDE - 1))
                begin
                    in_row_next    = '0;
                    row_phase_next = '0;
                    block_row_next = '0;
                end
                else
                begin
                    in_row_next = in_row_reg + 1'b1;
                    if (row_phase_reg == fm1)
                    begin
                        row_phase_next = '0;
                        block_row_next = block_row_reg + 1'b1;
                    end
                    else
                    begin
                        row_phase_next = row_phase_reg + 1'b1;
                    end
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
                if (col_phase_reg == fm1)
                begin
                    col_phase_next = '0;
                    block_col_next = block_col_reg + 1'b1;
                end
                else
                begin
                    col_phase_next = col_phase_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fac_reg       <= ibd_pkg::FAC_2;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            block_col_reg <= '0;
            block_row_reg <= '0;
        end
        else
        begin
            fac_reg       <= fac_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            block_col_reg <= block_col_next;
            block_row_reg <= block_row_next;
        end
    end

endmodule

// ===== rtl/ibd_queue.sv =====
module ibd_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ibd_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data,
    output logic         full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == (AW+1)'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/ibd_back.sv =====
module ibd_back #(
    parameter int SUM_DEPTH = ibd_pkg::SUM_DEPTH_DEF,
    parameter int COL_W     = $clog2(SUM_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic [COL_W-1:0]  q_col,
    input  ibd_pkg::blk_ctl_t q_ctl,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output ibd_pkg::result_t  result
);

    localparam int SW = ibd_pkg::SUM_W;
    localparam int CW = ibd_pkg::CHAN_W;
    localparam int EW = ibd_pkg::NUM_CHAN * SW;

    logic [EW-1:0]     sums_mem [SUM_DEPTH];
    logic [EW-1:0]     rd_reg;

    logic              b_valid_reg, b_valid_next;
    logic [COL_W-1:0]  b_col_reg;
    ibd_pkg::blk_ctl_t b_ctl_reg;

    logic              lw_valid_reg;
    logic [COL_W-1:0]  lw_col_reg;
    logic [EW-1:0]     lw_sum_reg;

    logic              res_valid_reg, res_valid_next;
    ibd_pkg::result_t  res_reg;

    logic              out_free;
    logic              b_fire;
    logic [EW-1:0]     base;
    logic [EW-1:0]     sum;
    logic [ibd_pkg::NUM_CHAN*CW-1:0] pix_vec;

    assign out_free = !res_valid_reg || !result_stall;
    assign b_fire   = b_valid_reg && (!b_ctl_reg.last || out_free);
    assign q_pop    = q_valid && (!b_valid_reg || b_fire);
    assign pix_vec  = b_ctl_reg.pix;

    // first pixel of a block starts from zero; latest write bypasses a read that raced it
    always_comb
    begin
        priority if (b_ctl_reg.first)
            base = '0;
        else if (lw_valid_reg && (lw_col_reg == b_col_reg))
            base = lw_sum_reg;
        else
            base = rd_reg;
        for (int c = 0; c < ibd_pkg::NUM_CHAN; c++)
        begin
            sum[c*SW +: SW] = base[c*SW +: SW] + SW'(pix_vec[c*CW +: CW]);
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (q_pop)
            b_valid_next = 1'b1;
        else if (b_fire)
            b_valid_next = 1'b0;
        res_valid_next = res_valid_reg;
        if (b_fire && b_ctl_reg.last)
            res_valid_next = 1'b1;
        else if (!result_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_reg    <= sums_mem[q_col];
            b_col_reg <= q_col;
            b_ctl_reg <= q_ctl;
        end
        if (b_fire)
        begin
            sums_mem[b_col_reg] <= sum;
            lw_col_reg          <= b_col_reg;
            lw_sum_reg          <= sum;
        end
        if (b_fire && b_ctl_reg.last)
        begin
            res_reg.red_avg    <= ibd_pkg::box_mean(sum[2*SW +: SW], b_ctl_reg.fac);
            res_reg.green_avg  <= ibd_pkg::box_mean(sum[1*SW +: SW], b_ctl_reg.fac);
            res_reg.blue_avg   <= ibd_pkg::box_mean(sum[0 +: SW], b_ctl_reg.fac);
            res_reg.out_col    <= b_ctl_reg.out_col;
            res_reg.out_row    <= b_ctl_reg.out_row;
            res_reg.frame_last <= b_ctl_reg.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            lw_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            res_valid_reg <= res_valid_next;
            if (b_fire)
                lw_valid_reg <= 1'b1;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/image_box_downscale.sv =====
// Box-filter downscaler for a square IMAGE_SIDE x IMAGE_SIDE RGB frame in raster order.
// Each channel is summed over non-overlapping f x f blocks (f = 2, 3 or 4 from the
// config register; 0 and 1 act as 2, 5 to 7 as 4) and one item with the truncated mean
// and the block's column and row (low 7 bits) comes out when the block's last pixel
// arrives; frame_last flags the final block. Trailing pixels that do not fill a block,
// and block columns at or past SUM_DEPTH, are dropped. One pixel is accepted every
// clock while pixel_stall is low; the rate is set by the line of accumulators, a single
// memory read and written once per pixel, with the latest write bypassed to the next
// read. A block's last pixel passes the queue, the accumulate stage and the result
// register to its result. The accumulators need no clearing pass: the first pixel of
// each block overwrites its entry. A config write takes the new factor and restarts
// the frame at pixel (0,0); write it only while idle.
module image_box_downscale #(
    parameter int IMAGE_SIDE = ibd_pkg::IMAGE_SIDE_DEF,
    parameter int SUM_DEPTH  = ibd_pkg::SUM_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ibd_pkg::CFG_W-1:0] cfg_data,
    input  logic                      pixel_valid,
    output logic                      pixel_stall,
    input  ibd_pkg::pixel_t           pixel,
    output logic                      result_valid,
    input  logic                      result_stall,
    output ibd_pkg::result_t          result
);

    localparam int COL_W = $clog2(SUM_DEPTH);
    localparam int QW    = COL_W + $bits(ibd_pkg::blk_ctl_t);

    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    logic              q_full;
    logic [COL_W-1:0]  f_col;
    ibd_pkg::blk_ctl_t f_ctl;
    logic [COL_W-1:0]  h_col;
    ibd_pkg::blk_ctl_t h_ctl;
    logic [QW-1:0]     h_data;

    assign cfg_ready   = 1'b1;
    assign pixel_stall = q_full;

    ibd_front #(
        .IMAGE_SIDE (IMAGE_SIDE),
        .SUM_DEPTH  (SUM_DEPTH),
        .COL_W      (COL_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_col       (f_col),
        .q_ctl       (f_ctl)
    );

    ibd_queue #(
        .W     (QW),
        .DEPTH (ibd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({f_col, f_ctl}),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (h_data),
        .full       (q_full)
    );

    assign h_col = h_data[QW-1 -: COL_W];
    assign h_ctl = h_data[QW-COL_W-1:0];

    ibd_back #(
        .SUM_DEPTH (SUM_DEPTH),
        .COL_W     (COL_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_col        (h_col),
        .q_ctl        (h_ctl),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    a_push_needs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (pixel_valid && !pixel_stall))
        else $error("queue push without an accepted pixel");
`endif

endmodule
